[sv/jtsp_pkg.sv]
`default_nettype none

package jtsp_pkg;

  localparam int BYTE_W     = 8;
  localparam int EV_W       = 4;
  localparam int IND_W      = 7;
  localparam int MANT_OUT_W = 40;
  localparam int FRAC_W     = 4;

  // event codes
  localparam logic [EV_W-1:0] EV_OBJ   = 4'd0;
  localparam logic [EV_W-1:0] EV_ARR   = 4'd1;
  localparam logic [EV_W-1:0] EV_CHAR  = 4'd2;
  localparam logic [EV_W-1:0] EV_SEND  = 4'd3;
  localparam logic [EV_W-1:0] EV_NUM   = 4'd4;
  localparam logic [EV_W-1:0] EV_TRUE  = 4'd5;
  localparam logic [EV_W-1:0] EV_FALSE = 4'd6;
  localparam logic [EV_W-1:0] EV_NULL  = 4'd7;
  localparam logic [EV_W-1:0] EV_DOC   = 4'd8;

  // characters of interest
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_POINT  = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
  localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_DIG0   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DIG9   = 8'h39;

  localparam logic [IND_W-1:0]  INDENT_MAX = 7'd127;
  localparam logic [FRAC_W-1:0] FRAC_MAX   = 4'd15;
  localparam int                DEC_BASE   = 10;

  // byte classes produced by the front end
  typedef enum logic [3:0] {
    CL_OPEN_OBJ,
    CL_OPEN_ARR,
    CL_QUOTE,
    CL_DIGIT,
    CL_POINT,
    CL_COLON,
    CL_COMMA,
    CL_CLOSE,
    CL_FALSE,
    CL_TRUE,
    CL_NULL,
    CL_END,
    CL_OTHER
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [EV_W-1:0]       event_res;
    logic [IND_W-1:0]      indent;
    logic [BYTE_W-1:0]     char_value;
    logic                  is_key;
    logic [MANT_OUT_W-1:0] mantissa;
    logic [FRAC_W-1:0]     frac_digits;
    logic                  num_overflow;
    logic                  depth_error;
    logic                  last;
  } res_t;

endpackage

`default_nettype wire

[sv/jtsp_in_if.sv]
`default_nettype none

interface jtsp_in_if;
  import jtsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

[sv/jtsp_out_if.sv]
`default_nettype none

interface jtsp_out_if;
  import jtsp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [EV_W-1:0]       event_res;
  logic [IND_W-1:0]      indent;
  logic [BYTE_W-1:0]     char_value;
  logic                  is_key;
  logic [MANT_OUT_W-1:0] mantissa;
  logic [FRAC_W-1:0]     frac_digits;
  logic                  num_overflow;
  logic                  depth_error;
  logic                  last;

  modport source (
    output valid, output event_res, output indent, output char_value, output is_key,
    output mantissa, output frac_digits, output num_overflow, output depth_error,
    output last, input ready
  );
  modport sink (
    input valid, input event_res, input indent, input char_value, input is_key,
    input mantissa, input frac_digits, input num_overflow, input depth_error,
    input last, output ready
  );
endinterface

`default_nettype wire

[sv/jtsp_front.sv]
`default_nettype none

module jtsp_front (
  input  logic            clk,
  input  logic            rst,
  jtsp_in_if.sink         byte_in,
  output jtsp_pkg::item_t item,
  output logic            item_valid,
  input  logic            item_ready
);
  import jtsp_pkg::*;

  localparam logic [1:0] FQ_DEPTH = 2'd2;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  function automatic cls_t classify(input logic [BYTE_W-1:0] b);
    cls_t c;
    c = CL_OTHER;
    case (b)
      CH_LBRACE:           c = CL_OPEN_OBJ;
      CH_LBRACK:           c = CL_OPEN_ARR;
      CH_QUOTE:            c = CL_QUOTE;
      CH_POINT:            c = CL_POINT;
      CH_COLON:            c = CL_COLON;
      CH_COMMA:            c = CL_COMMA;
      CH_RBRACE, CH_RBRACK: c = CL_CLOSE;
      CH_F:                c = CL_FALSE;
      CH_T:                c = CL_TRUE;
      CH_N:                c = CL_NULL;
      CH_NUL:              c = CL_END;
      default:             c = (b inside {[CH_DIG0:CH_DIG9]}) ? CL_DIGIT : CL_OTHER;
    endcase
    return c;
  endfunction

  assign byte_in.ready = (count != FQ_DEPTH);
  assign push          = byte_in.valid && byte_in.ready;
  assign item_valid    = (count != 2'd0);
  assign pop           = item_valid && item_ready;
  assign item          = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // classified bytes, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{cls: classify(byte_in.text_byte), data: byte_in.text_byte};
    end
  end

endmodule

`default_nettype wire

[sv/jtsp_back.sv]
`default_nettype none

module jtsp_back #(
  parameter int NEST_MAX  = 32,
  parameter int MANT_BITS = 40
) (
  input  logic            clk,
  input  logic            rst,
  input  jtsp_pkg::item_t item,
  input  logic            item_valid,
  output logic            item_ready,
  jtsp_out_if.source      event_out
);
  import jtsp_pkg::*;

  localparam int IW = $clog2(NEST_MAX);
  localparam int NW = $clog2(NEST_MAX + 1);
  localparam int PW = MANT_BITS + 4;
  localparam int EW = (MANT_BITS > MANT_OUT_W) ? MANT_BITS : MANT_OUT_W;
  localparam logic [NW-1:0] NEST_FULL = NW'(NEST_MAX);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;

  typedef enum logic [2:0] {
    M_NORMAL,
    M_STRING,
    M_AFTER_STR,
    M_NUMBER,
    M_SKIP
  } mode_t;

  // scanner state
  mode_t                mode, mode_next;
  logic [1:0]           skip_left, skip_left_next;
  logic [IND_W-1:0]     indent_level, indent_level_next;
  logic                 key_pending, key_pending_next;
  logic [NW-1:0]        nest_count, nest_count_next;
  logic [MANT_BITS-1:0] mantissa_acc, mantissa_acc_next;
  logic [FRAC_W-1:0]    frac_count, frac_count_next;
  logic                 seen_point, seen_point_next;
  logic                 overflow_flag, overflow_flag_next;
  logic                 error_flag, error_flag_next;
  logic                 top_bit, top_bit_next;
  logic                 below_bit;

  // stack below the top entry
  logic          stack_mem [NEST_MAX];
  logic          stk_we;
  logic [IW-1:0] stk_waddr;
  logic [IW-1:0] stk_raddr;

  // result queue
  res_t               rq [RQ_DEPTH];
  logic [RQ_AW-1:0]   rq_wr, rq_rd;
  logic [RQ_AW:0]     rq_count;
  logic               rq_pop;
  res_t               res0, res1;
  logic [1:0]         n_res;

  logic                  take;
  logic [EW-1:0]         acc_ext;
  logic [MANT_OUT_W-1:0] acc_out;

  assign acc_ext = EW'(mantissa_acc);
  assign acc_out = acc_ext[MANT_OUT_W-1:0];

  assign item_ready = (rq_count <= (RQ_AW+1)'(RQ_DEPTH - 2));
  assign take       = item_valid && item_ready;

  function automatic res_t mk_res(
    input logic [EV_W-1:0]       ev,
    input logic [IND_W-1:0]      ind,
    input logic [BYTE_W-1:0]     ch,
    input logic                  key,
    input logic [MANT_OUT_W-1:0] mant,
    input logic [FRAC_W-1:0]     frac,
    input logic                  ovf,
    input logic                  derr
  );
    res_t r;
    r.event_res    = ev;
    r.indent       = ind;
    r.char_value   = ch;
    r.is_key       = key;
    r.mantissa     = mant;
    r.frac_digits  = frac;
    r.num_overflow = ovf;
    r.depth_error  = derr;
    r.last         = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic           normal;
    logic           doc;
    logic           digit;
    logic           e1_v, e2_v;
    res_t           e1, e2;
    logic [PW-1:0]  prod;
    logic [3:0]     dval;

    mode_next          = mode;
    skip_left_next     = skip_left;
    indent_level_next  = indent_level;
    key_pending_next   = key_pending;
    nest_count_next    = nest_count;
    mantissa_acc_next  = mantissa_acc;
    frac_count_next    = frac_count;
    seen_point_next    = seen_point;
    overflow_flag_next = overflow_flag;
    error_flag_next    = error_flag;
    top_bit_next       = top_bit;
    stk_we             = 1'b0;
    stk_waddr          = IW'(nest_count - NW'(1));
    normal             = 1'b0;
    doc                = 1'b0;
    digit              = 1'b0;
    e1_v               = 1'b0;
    e2_v               = 1'b0;
    e1                 = '0;
    e2                 = '0;
    dval               = item.data[3:0];
    prod               = '0;

    if (take) begin
      case (mode)
        M_STRING: begin
          if (item.cls == CL_QUOTE) begin
            mode_next = M_AFTER_STR;
          end else if (item.cls == CL_END) begin
            doc = 1'b1;
          end else begin
            e1_v = 1'b1;
            e1   = mk_res(EV_CHAR, indent_level, item.data, 1'b0, '0, '0, 1'b0, 1'b0);
          end
        end
        M_AFTER_STR: begin
          mode_next = M_NORMAL;
          if (item.cls == CL_COLON) begin
            e1_v = 1'b1;
            e1   = mk_res(EV_SEND, indent_level, '0, 1'b1, '0, '0, 1'b0, 1'b0);
            if (indent_level_next < INDENT_MAX) begin
              indent_level_next = indent_level_next + IND_W'(1);
            end
            key_pending_next = 1'b1;
          end else begin
            e1_v   = 1'b1;
            e1     = mk_res(EV_SEND, indent_level, '0, 1'b0, '0, '0, 1'b0, 1'b0);
            normal = 1'b1;
          end
        end
        M_NUMBER: begin
          if (item.cls == CL_DIGIT) begin
            digit = 1'b1;
          end else if (item.cls == CL_POINT) begin
            seen_point_next = 1'b1;
          end else begin
            e1_v      = 1'b1;
            e1        = mk_res(EV_NUM, indent_level, '0, 1'b0, acc_out, frac_count,
                               overflow_flag, 1'b0);
            mode_next = M_NORMAL;
            normal    = 1'b1;
          end
        end
        M_SKIP: begin
          if (item.cls == CL_END) begin
            doc = 1'b1;
          end else if (skip_left == 2'd0) begin
            mode_next = M_NORMAL;
          end else begin
            skip_left_next = skip_left - 2'd1;
          end
        end
        default: begin
          mode_next = M_NORMAL;
          normal    = 1'b1;
        end
      endcase

      if (normal) begin
        case (item.cls)
          CL_OPEN_OBJ, CL_OPEN_ARR: begin
            e2_v = 1'b1;
            e2   = mk_res((item.cls == CL_OPEN_OBJ) ? EV_OBJ : EV_ARR, indent_level_next,
                          '0, 1'b0, '0, '0, 1'b0, 1'b0);
            if (indent_level_next < INDENT_MAX) begin
              indent_level_next = indent_level_next + IND_W'(1);
            end
            if (nest_count_next < NEST_FULL) begin
              // old top goes down into the memory
              if (nest_count_next != '0) begin
                stk_we    = 1'b1;
                stk_waddr = IW'(nest_count_next - NW'(1));
              end
              top_bit_next    = key_pending_next;
              nest_count_next = nest_count_next + NW'(1);
            end else begin
              error_flag_next = 1'b1;
            end
            key_pending_next = 1'b0;
          end
          CL_QUOTE: begin
            mode_next = M_STRING;
          end
          CL_DIGIT: begin
            mode_next          = M_NUMBER;
            mantissa_acc_next  = '0;
            frac_count_next    = '0;
            seen_point_next    = 1'b0;
            overflow_flag_next = 1'b0;
            digit              = 1'b1;
          end
          CL_COMMA: begin
            if (key_pending_next) begin
              key_pending_next = 1'b0;
              if (indent_level_next != '0) begin
                indent_level_next = indent_level_next - IND_W'(1);
              end
            end
          end
          CL_CLOSE: begin
            if (key_pending_next) begin
              key_pending_next = 1'b0;
              if (indent_level_next != '0) begin
                indent_level_next = indent_level_next - IND_W'(1);
              end
            end
            if (indent_level_next != '0) begin
              indent_level_next = indent_level_next - IND_W'(1);
            end
            if (nest_count_next != '0) begin
              nest_count_next  = nest_count_next - NW'(1);
              key_pending_next = top_bit;
              top_bit_next     = below_bit;
            end else begin
              error_flag_next = 1'b1;
            end
          end
          CL_FALSE: begin
            e2_v           = 1'b1;
            e2             = mk_res(EV_FALSE, indent_level_next, '0, 1'b0, '0, '0, 1'b0,
                                    1'b0);
            mode_next      = M_SKIP;
            skip_left_next = 2'd3;
          end
          CL_TRUE: begin
            e2_v           = 1'b1;
            e2             = mk_res(EV_TRUE, indent_level_next, '0, 1'b0, '0, '0, 1'b0,
                                    1'b0);
            mode_next      = M_SKIP;
            skip_left_next = 2'd2;
          end
          CL_NULL: begin
            e2_v           = 1'b1;
            e2             = mk_res(EV_NULL, indent_level_next, '0, 1'b0, '0, '0, 1'b0,
                                    1'b0);
            mode_next      = M_SKIP;
            skip_left_next = 2'd2;
          end
          CL_END: begin
            doc = 1'b1;
          end
          default: begin
          end
        endcase
      end

      // decimal digit: fraction count first, then saturating shift-add
      if (digit) begin
        if (seen_point_next && (frac_count_next >= FRAC_MAX)) begin
          overflow_flag_next = 1'b1;
        end else begin
          if (seen_point_next) begin
            frac_count_next = frac_count_next + FRAC_W'(1);
          end
          prod = PW'(mantissa_acc_next) * PW'(DEC_BASE) + PW'(dval);
          if (prod[PW-1:MANT_BITS] != '0) begin
            mantissa_acc_next  = '1;
            overflow_flag_next = 1'b1;
          end else begin
            mantissa_acc_next = prod[MANT_BITS-1:0];
          end
        end
      end

      if (doc) begin
        e2_v = 1'b1;
        e2   = mk_res(EV_DOC, indent_level, '0, 1'b0, '0, '0, 1'b0,
                      error_flag || (nest_count != '0));
        mode_next          = M_NORMAL;
        skip_left_next     = '0;
        indent_level_next  = '0;
        key_pending_next   = 1'b0;
        nest_count_next    = '0;
        mantissa_acc_next  = '0;
        frac_count_next    = '0;
        seen_point_next    = 1'b0;
        overflow_flag_next = 1'b0;
        error_flag_next    = 1'b0;
      end
    end

    res0      = e1_v ? e1 : e2;
    res0.last = !(e1_v && e2_v);
    res1      = e2;
    res1.last = 1'b1;
    n_res     = {1'b0, e1_v} + {1'b0, e2_v};
    stk_raddr = IW'(nest_count_next - NW'(2));
  end

  assign event_out.valid        = (rq_count != '0);
  assign event_out.event_res    = rq[rq_rd].event_res;
  assign event_out.indent       = rq[rq_rd].indent;
  assign event_out.char_value   = rq[rq_rd].char_value;
  assign event_out.is_key       = rq[rq_rd].is_key;
  assign event_out.mantissa     = rq[rq_rd].mantissa;
  assign event_out.frac_digits  = rq[rq_rd].frac_digits;
  assign event_out.num_overflow = rq[rq_rd].num_overflow;
  assign event_out.depth_error  = rq[rq_rd].depth_error;
  assign event_out.last         = rq[rq_rd].last;
  assign rq_pop                 = event_out.valid && event_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_NORMAL;
      skip_left     <= '0;
      indent_level  <= '0;
      key_pending   <= 1'b0;
      nest_count    <= '0;
      mantissa_acc  <= '0;
      frac_count    <= '0;
      seen_point    <= 1'b0;
      overflow_flag <= 1'b0;
      error_flag    <= 1'b0;
      rq_wr         <= '0;
      rq_rd         <= '0;
      rq_count      <= '0;
    end else begin
      mode          <= mode_next;
      skip_left     <= skip_left_next;
      indent_level  <= indent_level_next;
      key_pending   <= key_pending_next;
      nest_count    <= nest_count_next;
      mantissa_acc  <= mantissa_acc_next;
      frac_count    <= frac_count_next;
      seen_point    <= seen_point_next;
      overflow_flag <= overflow_flag_next;
      error_flag    <= error_flag_next;
      top_bit       <= top_bit_next;
      if (n_res != 2'd0) begin
        rq[rq_wr] <= res0;
      end
      if (n_res == 2'd2) begin
        rq[rq_wr + RQ_AW'(1)] <= res1;
      end
      rq_wr    <= rq_wr + RQ_AW'(n_res);
      if (rq_pop) begin
        rq_rd <= rq_rd + RQ_AW'(1);
      end
      rq_count <= rq_count + (RQ_AW+1)'(n_res) - (RQ_AW+1)'(rq_pop);
    end
  end

  // stack memory with registered read of the entry under the top, write bypassed
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= top_bit;
    end
    below_bit <= (stk_we && (stk_waddr == stk_raddr)) ? top_bit : stack_mem[stk_raddr];
  end

endmodule

`default_nettype wire

[sv/json_token_stream_parser.sv]
// path: a byte is classified into the front queue, then the scanner writes its events into the result queue
// throughput: one byte per cycle while the result queue has room for two events; the result
//   queue has a single read port, so a byte with two events hands them out one at a time
// reset: synchronous active-high rst clears both queues and all scanner state but the top stack bit at once;
//   the nesting stack memory is not cleared and is only read below the fill count
`default_nettype none

module json_token_stream_parser #(
  parameter int NEST_MAX  = 32,
  parameter int MANT_BITS = 40
) (
  input  logic       clk,
  input  logic       rst,
  jtsp_in_if.sink    byte_in,
  jtsp_out_if.source event_out
);
  import jtsp_pkg::*;

  // classified byte handed from the front end to the scanner
  item_t item;
  logic  item_valid;
  logic  item_ready;

  // front: takes text bytes, sorts them into classes, small queue
  jtsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  // back: scanner state, nesting stack, number accumulator and result queue;
  // it takes an item only when the result queue has room for two events
  jtsp_back #(
    .NEST_MAX  (NEST_MAX),
    .MANT_BITS (MANT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .event_out  (event_out)
  );

endmodule

`default_nettype wire
